FILE: design/router_advert_frame_checker_core_defines.svh
// Assertion macros for the router advertisement frame checker.
`ifndef ROUTER_ADVERT_FRAME_CHECKER_CORE_DEFINES_SVH
`define ROUTER_ADVERT_FRAME_CHECKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RAFC_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rafc assertion failed");
`define RAFC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rafc assertion failed");
`else
`define RAFC_ASSERT_IMP(lbl, pre, post)
`define RAFC_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: design/rafc_pkg.sv
// Types and constants shared by the router advertisement frame checker.
package rafc_pkg;

  localparam int RAFC_MAX_ENTRIES = 16;
  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] ICMP_ROUTER_ADVERT = 8'd9;
  localparam logic [7:0] ENTRY_SIZE_WORDS = 8'd2;

  typedef enum logic [3:0] {
    V_ACCEPT    = 4'd0,
    V_SHORT     = 4'd1,
    V_ETHERTYPE = 4'd2,
    V_IHL       = 4'd3,
    V_TOTAL_LEN = 4'd4,
    V_PROTOCOL  = 4'd5,
    V_TYPE      = 4'd6,
    V_CODE      = 4'd7,
    V_ENTRY_SIZE = 4'd8,
    V_ADDR_COUNT = 4'd9
  } verdict_t;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_JUDGE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } frame_beat_t;

  typedef struct packed {
    logic               record_kind;
    verdict_t           verdict;
    logic [31:0]        source_address;
    logic [31:0]        dest_address;
    logic [15:0]        advert_lifetime;
    logic [7:0]         address_count;
    logic               entries_truncated;
    logic [31:0]        router_address;
    logic signed [31:0] preference_level;
    logic [7:0]         entry_number;
    logic               last_record;
  } record_beat_t;

endpackage

FILE: design/router_advert_frame_checker_core.sv
// Router advertisement frame checker: byte capture, verdict and entry record output.
`include "router_advert_frame_checker_core_defines.svh"

// Frame bytes are taken one per cycle while a frame streams in; the entry
// pairs are written to an on-chip entry memory as they arrive. The beat that
// carries end_of_frame is followed by a judging state that loads the verdict
// record; for an accepted frame up to MAX_ENTRIES entry records follow, one
// per cycle while the output side does not stall, read from the single read
// port of the entry memory. Input stalls after the last byte until the final
// record is loaded into the output register.
module router_advert_frame_checker_core #(
  parameter int MAX_ENTRIES = rafc_pkg::RAFC_MAX_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  rafc_pkg::frame_beat_t  byte_data,
  output logic                   rec_valid,
  input  logic                   rec_stall,
  output rafc_pkg::record_beat_t rec_data
);
  import rafc_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [POS_W-1:0] LIST_SPAN = POS_W'(8 * MAX_ENTRIES);
  localparam logic [7:0] MAX_SHOWN = 8'(MAX_ENTRIES);

  state_t state, state_next;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0] ether_kind, ether_kind_next;
  logic [3:0]  header_words, header_words_next;
  logic [15:0] ip_total_length, ip_total_length_next;
  logic [7:0]  ip_protocol, ip_protocol_next;
  logic [31:0] src_addr_reg, src_addr_reg_next;
  logic [31:0] dst_addr_reg, dst_addr_reg_next;
  logic [47:0] icmp_fields, icmp_fields_next;
  logic [63:0] entry_shift, entry_shift_next;

  logic [63:0] entry_store [MAX_ENTRIES];
  logic [63:0] rd_data;
  logic [AW-1:0] emit_idx, emit_idx_next;
  logic [7:0] shown_reg, shown_reg_next;

  record_beat_t rec_next;
  logic rec_valid_next;

  logic accept, out_free, load, clear;
  logic [POS_W-1:0] len, icmp_at, list_at, k_off, e_off;
  logic in_icmp, in_list, store_we;
  logic [AW-1:0] store_addr;

  verdict_t verdict;
  logic [17:0] len18, hl18, tl18, cnt18;
  logic [7:0] cnt, shown;

  assign accept   = byte_valid && !byte_stall;
  assign out_free = !rec_valid || !rec_stall;
  assign byte_stall = (state != ST_RECV);

  // byte capture
  assign len     = (byte_position < POS_MAX) ? byte_position + POS_W'(1) : POS_MAX;
  assign icmp_at = POS_W'(14) + POS_W'({header_words, 2'b00});
  assign list_at = icmp_at + POS_W'(8);
  assign k_off   = byte_position - icmp_at;
  assign e_off   = byte_position - list_at;
  assign in_icmp = (header_words >= 4'd5) && (byte_position >= icmp_at) &&
                   (byte_position < list_at) && (k_off != POS_W'(2)) &&
                   (k_off != POS_W'(3));
  assign in_list = (header_words >= 4'd5) && (byte_position >= list_at) &&
                   (byte_position < list_at + LIST_SPAN);
  assign store_we   = accept && in_list && (e_off[2:0] == 3'b111);
  assign store_addr = e_off[AW+2:3];

  always_comb begin
    byte_position_next   = byte_position;
    ether_kind_next      = ether_kind;
    header_words_next    = header_words;
    ip_total_length_next = ip_total_length;
    ip_protocol_next     = ip_protocol;
    src_addr_reg_next    = src_addr_reg;
    dst_addr_reg_next    = dst_addr_reg;
    icmp_fields_next     = icmp_fields;
    entry_shift_next     = entry_shift;
    if (accept) begin
      byte_position_next = len;
      if (byte_position == POS_W'(12) || byte_position == POS_W'(13))
        ether_kind_next = {ether_kind[7:0], byte_data.frame_byte};
      if (byte_position == POS_W'(14))
        header_words_next = byte_data.frame_byte[3:0];
      if (byte_position == POS_W'(16) || byte_position == POS_W'(17))
        ip_total_length_next = {ip_total_length[7:0], byte_data.frame_byte};
      if (byte_position == POS_W'(23))
        ip_protocol_next = byte_data.frame_byte;
      if (byte_position >= POS_W'(26) && byte_position <= POS_W'(29))
        src_addr_reg_next = {src_addr_reg[23:0], byte_data.frame_byte};
      if (byte_position >= POS_W'(30) && byte_position <= POS_W'(33))
        dst_addr_reg_next = {dst_addr_reg[23:0], byte_data.frame_byte};
      if (in_icmp)
        icmp_fields_next = {icmp_fields[39:0], byte_data.frame_byte};
      if (in_list)
        entry_shift_next = {entry_shift[55:0], byte_data.frame_byte};
    end
    if (clear) begin
      byte_position_next   = '0;
      ether_kind_next      = '0;
      header_words_next    = '0;
      ip_total_length_next = '0;
      ip_protocol_next     = '0;
      src_addr_reg_next    = '0;
      dst_addr_reg_next    = '0;
      icmp_fields_next     = '0;
      entry_shift_next     = '0;
    end
  end

  // verdict, from the registered frame fields
  assign cnt   = icmp_fields[31:24];
  assign len18 = 18'(byte_position);
  assign hl18  = 18'({header_words, 2'b00});
  assign tl18  = 18'(ip_total_length);
  assign cnt18 = 18'({cnt, 3'b000});

  always_comb begin
    priority if (len18 < 18'd42) verdict = V_SHORT;
    else if (ether_kind != ETHERTYPE_IPV4) verdict = V_ETHERTYPE;
    else if (hl18 < 18'd20 || len18 < 18'd22 + hl18) verdict = V_IHL;
    else if (tl18 < hl18 + 18'd8 || len18 < 18'd14 + tl18) verdict = V_TOTAL_LEN;
    else if (ip_protocol != PROTO_ICMP) verdict = V_PROTOCOL;
    else if (icmp_fields[47:40] != ICMP_ROUTER_ADVERT) verdict = V_TYPE;
    else if (icmp_fields[39:32] != 8'd0) verdict = V_CODE;
    else if (icmp_fields[23:16] != ENTRY_SIZE_WORDS) verdict = V_ENTRY_SIZE;
    else if (tl18 < hl18 + 18'd8 + cnt18) verdict = V_ADDR_COUNT;
    else verdict = V_ACCEPT;
  end

  assign shown = (verdict != V_ACCEPT) ? 8'd0 : ((cnt > MAX_SHOWN) ? MAX_SHOWN : cnt);

  // sequencer
  always_comb begin
    state_next     = state;
    load           = 1'b0;
    clear          = 1'b0;
    rec_next       = rec_data;
    emit_idx_next  = emit_idx;
    shown_reg_next = shown_reg;
    unique case (state)
      ST_RECV: begin
        if (accept && byte_data.end_of_frame) state_next = ST_JUDGE;
      end
      ST_JUDGE: begin
        if (out_free) begin
          load  = 1'b1;
          clear = 1'b1;
          rec_next = '0;
          rec_next.verdict = verdict;
          if (verdict == V_ACCEPT) begin
            rec_next.source_address    = src_addr_reg;
            rec_next.dest_address      = dst_addr_reg;
            rec_next.advert_lifetime   = icmp_fields[15:0];
            rec_next.address_count     = cnt;
            rec_next.entries_truncated = (cnt > MAX_SHOWN);
          end
          rec_next.last_record = (shown == 8'd0);
          shown_reg_next = shown;
          emit_idx_next  = '0;
          state_next     = (shown == 8'd0) ? ST_RECV : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          rec_next.record_kind      = 1'b1;
          rec_next.verdict          = V_ACCEPT;
          rec_next.router_address   = rd_data[63:32];
          rec_next.preference_level = signed'(rd_data[31:0]);
          rec_next.entry_number     = 8'(emit_idx);
          rec_next.last_record      = (8'(emit_idx) + 8'd1 == shown_reg);
          emit_idx_next = emit_idx + AW'(1);
          if (rec_next.last_record) state_next = ST_RECV;
        end
      end
      default: state_next = ST_RECV;
    endcase
  end

  assign rec_valid_next = load || (rec_valid && rec_stall);

  // entry memory: written while bytes arrive, read one entry ahead while emitting
  always_ff @(posedge clk) begin
    if (store_we) entry_store[store_addr] <= entry_shift_next;
    rd_data <= entry_store[emit_idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_RECV;
      rec_valid       <= 1'b0;
      byte_position   <= '0;
      ether_kind      <= '0;
      header_words    <= '0;
      ip_total_length <= '0;
      ip_protocol     <= '0;
      src_addr_reg    <= '0;
      dst_addr_reg    <= '0;
      icmp_fields     <= '0;
      entry_shift     <= '0;
      emit_idx        <= '0;
      shown_reg       <= '0;
    end else begin
      state           <= state_next;
      rec_valid       <= rec_valid_next;
      byte_position   <= byte_position_next;
      ether_kind      <= ether_kind_next;
      header_words    <= header_words_next;
      ip_total_length <= ip_total_length_next;
      ip_protocol     <= ip_protocol_next;
      src_addr_reg    <= src_addr_reg_next;
      dst_addr_reg    <= dst_addr_reg_next;
      icmp_fields     <= icmp_fields_next;
      entry_shift     <= entry_shift_next;
      emit_idx        <= emit_idx_next;
      shown_reg       <= shown_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) rec_data <= rec_next;
  end

  `RAFC_ASSERT_NEXT(a_last_byte_judged, byte_valid && !byte_stall && byte_data.end_of_frame, state == ST_JUDGE)
  `RAFC_ASSERT_IMP(a_emit_in_range, state == ST_EMIT, 8'(emit_idx) < shown_reg)
  `RAFC_ASSERT_IMP(a_entry_of_accepted, rec_valid && rec_data.record_kind, rec_data.verdict == V_ACCEPT && rec_data.entry_number < shown_reg)

endmodule

FILE: tb/testbench.sv
// Testbench for router_advert_frame_checker_core: frame stimulus, record prediction and checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rafc_pkg::*;

  localparam int MAX_ENTRIES = RAFC_MAX_ENTRIES;

  logic         clk;
  logic         rst;
  logic         byte_valid;
  logic         byte_stall;
  frame_beat_t  byte_data;
  logic         rec_valid;
  logic         rec_stall;
  record_beat_t rec_data;

  router_advert_frame_checker_core #(.MAX_ENTRIES(MAX_ENTRIES)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data (byte_data),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec_data  (rec_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // predicted frame state
  logic [POS_W-1:0] pos_q = '0;
  logic [15:0]      ether_q = '0;
  logic [3:0]       ihl_q = '0;
  logic [15:0]      total_q = '0;
  logic [7:0]       proto_q = '0;
  logic [31:0]      src_q = '0;
  logic [31:0]      dst_q = '0;
  logic [47:0]      icmp_q = '0;
  logic [63:0]      pair_shift_q = '0;
  logic [63:0]      entry_mem [MAX_ENTRIES];

  record_beat_t pending_records[$];
  logic [7:0]   frame_buf[$];

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          errors = 0;
  int          bytes_sent = 0;
  int          frames_sent = 0;
  int          frames_accepted = 0;
  int          records_checked = 0;
  logic [9:0]  verdicts_seen = '0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic verdict_t judge_frame(input int len);
    int hl;
    int tl;
    hl = 4 * int'(ihl_q);
    tl = int'(total_q);
    if (len < 42) return V_SHORT;
    if (ether_q != ETHERTYPE_IPV4) return V_ETHERTYPE;
    if (hl < 20 || len < 14 + hl + 8) return V_IHL;
    if (tl < hl + 8 || len < 14 + tl) return V_TOTAL_LEN;
    if (proto_q != PROTO_ICMP) return V_PROTOCOL;
    if (icmp_q[47:40] != ICMP_ROUTER_ADVERT) return V_TYPE;
    if (icmp_q[39:32] != 8'd0) return V_CODE;
    if (icmp_q[23:16] != ENTRY_SIZE_WORDS) return V_ENTRY_SIZE;
    if (tl < hl + 8 + 8 * int'(icmp_q[31:24]) || len < 14 + tl) return V_ADDR_COUNT;
    return V_ACCEPT;
  endfunction

  // Advance the frame model by one byte; on the last byte queue the records.
  function automatic void take_frame_byte(input logic [7:0] b, input logic eof);
    int           pos;
    int           len;
    int           icmp_at;
    int           list_at;
    int           off;
    int           shown;
    logic         trunc;
    verdict_t     v;
    record_beat_t r;
    logic [63:0]  e;
    pos = int'(pos_q);
    len = (pos < int'(POS_MAX)) ? pos + 1 : int'(POS_MAX);
    if (pos == 12 || pos == 13) ether_q = {ether_q[7:0], b};
    if (pos == 14) ihl_q = b[3:0];
    if (pos == 16 || pos == 17) total_q = {total_q[7:0], b};
    if (pos == 23) proto_q = b;
    if (pos >= 26 && pos <= 29) src_q = {src_q[23:0], b};
    if (pos >= 30 && pos <= 33) dst_q = {dst_q[23:0], b};
    if (ihl_q >= 4'd5) begin
      icmp_at = 14 + 4 * int'(ihl_q);
      list_at = icmp_at + 8;
      if (pos >= icmp_at && pos < list_at && pos - icmp_at != 2 && pos - icmp_at != 3)
        icmp_q = {icmp_q[39:0], b};
      if (pos >= list_at && pos < list_at + 8 * MAX_ENTRIES) begin
        off = pos - list_at;
        pair_shift_q = {pair_shift_q[55:0], b};
        if (off % 8 == 7) entry_mem[off / 8] = pair_shift_q;
      end
    end
    if (!eof) begin
      pos_q = POS_W'(len);
      return;
    end
    v = judge_frame(len);
    verdicts_seen[v] = 1'b1;
    trunc = (v == V_ACCEPT) && (int'(icmp_q[31:24]) > MAX_ENTRIES);
    shown = (v != V_ACCEPT) ? 0 : (trunc ? MAX_ENTRIES : int'(icmp_q[31:24]));
    if (v == V_ACCEPT) frames_accepted++;
    for (int i = 0; i <= shown; i++) begin
      r = '0;
      r.record_kind = (i != 0);
      r.verdict = (i == 0) ? v : V_ACCEPT;
      if (v == V_ACCEPT) begin
        r.source_address = src_q;
        r.dest_address = dst_q;
        r.advert_lifetime = icmp_q[15:0];
        r.address_count = icmp_q[31:24];
        r.entries_truncated = trunc;
      end
      if (i != 0) begin
        e = entry_mem[i - 1];
        r.router_address = e[63:32];
        r.preference_level = e[31:0];
        r.entry_number = 8'(i - 1);
      end
      r.last_record = (i == shown);
      pending_records.push_back(r);
    end
    pos_q = '0;
    ether_q = '0;
    ihl_q = '0;
    total_q = '0;
    proto_q = '0;
    src_q = '0;
    dst_q = '0;
    icmp_q = '0;
    pair_shift_q = '0;
  endfunction

  // Called and returns at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= '{frame_byte: b, end_of_frame: eof};
    do @(posedge clk); while (byte_stall);
    take_frame_byte(b, eof);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    do @(negedge clk); while (pending_records.size() != 0);
  endtask

  task automatic build_advert(input logic [15:0] etype, input logic [3:0] ihl,
                              input int tot_adj, input logic [7:0] proto,
                              input logic [7:0] icmp_type, input logic [7:0] code,
                              input logic [7:0] count, input logic [7:0] size,
                              input logic [15:0] life, input int n_list, input int pad);
    int          hdr;
    logic [15:0] tl;
    hdr = (ihl < 4'd5) ? 20 : 4 * int'(ihl);
    tl = 16'(hdr + 8 + 8 * n_list + tot_adj);
    frame_buf.delete();
    repeat (12) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(etype[15:8]);
    frame_buf.push_back(etype[7:0]);
    frame_buf.push_back({4'($urandom), ihl});
    frame_buf.push_back(8'($urandom));
    frame_buf.push_back(tl[15:8]);
    frame_buf.push_back(tl[7:0]);
    repeat (5) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(proto);
    repeat (hdr - 10) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(icmp_type);
    frame_buf.push_back(code);
    repeat (2) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(count);
    frame_buf.push_back(size);
    frame_buf.push_back(life[15:8]);
    frame_buf.push_back(life[7:0]);
    repeat (8 * n_list + pad) frame_buf.push_back(8'($urandom));
  endtask

  task automatic build_raw(input int len);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom));
  endtask

  task automatic test_short_frames();
    build_raw(1);
    send_frame();
    build_raw(41);
    send_frame();
    build_advert(ETHERTYPE_IPV4, 5, 0, PROTO_ICMP, ICMP_ROUTER_ADVERT, 0, 0,
                 ENTRY_SIZE_WORDS, 16'h1234, 0, 0);
    void'(frame_buf.pop_back());
    send_frame();
    build_raw(42);
    send_frame();
    wait_drained();
  endtask

  task automatic test_rejected_frames();
    build_advert(16'h86DD, 5, 0, PROTO_ICMP, ICMP_ROUTER_ADVERT, 0, 1, ENTRY_SIZE_WORDS,
                 16'h0708, 1, 0);
    send_frame();
    build_advert(ETHERTYPE_IPV4, 4, 0, PROTO_ICMP, ICMP_ROUTER_ADVERT, 0, 1,
                 ENTRY_SIZE_WORDS, 16'h0708, 1, 0);
    send_frame();
    // header claims more than the frame holds
    build_advert(ETHERTYPE_IPV4, 15, 0, PROTO_ICMP, ICMP_ROUTER_ADVERT, 0, 0,
                 ENTRY_SIZE_WORDS, 16'h0708, 0, 0);
    repeat (5) void'(frame_buf.pop_back());
    send_frame();
    build_advert(ETHERTYPE_IPV4, 5, -1, PROTO_ICMP, ICMP_ROUTER_ADVERT, 0, 0,
                 ENTRY_SIZE_WORDS, 16'h0708, 0, 0);
    send_frame();
    build_advert(ETHERTYPE_IPV4, 5, 1, PROTO_ICMP, ICMP_ROUTER_ADVERT, 0, 0,
                 ENTRY_SIZE_WORDS, 16'h0708, 0, 0);
    send_frame();
    build_advert(ETHERTYPE_IPV4, 5, 0, 8'd6, ICMP_ROUTER_ADVERT, 0, 1, ENTRY_SIZE_WORDS,
                 16'h0708, 1, 0);
    send_frame();
    build_advert(ETHERTYPE_IPV4, 5, 0, PROTO_ICMP, 8'd10, 0, 1, ENTRY_SIZE_WORDS,
                 16'h0708, 1, 0);
    send_frame();
    build_advert(ETHERTYPE_IPV4, 5, 0, PROTO_ICMP, ICMP_ROUTER_ADVERT, 8'd1, 1,
                 ENTRY_SIZE_WORDS, 16'h0708, 1, 0);
    send_frame();
    build_advert(ETHERTYPE_IPV4, 5, 0, PROTO_ICMP, ICMP_ROUTER_ADVERT, 0, 1, 8'd4,
                 16'h0708, 1, 0);
    send_frame();
    build_advert(ETHERTYPE_IPV4, 5, 0, PROTO_ICMP, ICMP_ROUTER_ADVERT, 0, 3,
                 ENTRY_SIZE_WORDS, 16'h0708, 2, 0);
    send_frame();
    wait_drained();
  endtask

  task automatic test_accepted_frames();
    build_advert(ETHERTYPE_IPV4, 5, 0, PROTO_ICMP, ICMP_ROUTER_ADVERT, 0, 0,
                 ENTRY_SIZE_WORDS, 16'h0000, 0, 0);
    send_frame();
    build_advert(ETHERTYPE_IPV4, 5, 0, PROTO_ICMP, ICMP_ROUTER_ADVERT, 0, 1,
                 ENTRY_SIZE_WORDS, 16'hFFFF, 1, 0);
    send_frame();
    build_advert(ETHERTYPE_IPV4, 6, 0, PROTO_ICMP, ICMP_ROUTER_ADVERT, 0, 8'(MAX_ENTRIES),
                 ENTRY_SIZE_WORDS, 16'(($urandom)), MAX_ENTRIES, 0);
    send_frame();
    // one pair more than the buffer holds
    build_advert(ETHERTYPE_IPV4, 5, 0, PROTO_ICMP, ICMP_ROUTER_ADVERT, 0,
                 8'(MAX_ENTRIES + 1), ENTRY_SIZE_WORDS, 16'($urandom), MAX_ENTRIES + 1, 0);
    send_frame();
    build_advert(ETHERTYPE_IPV4, 15, 0, PROTO_ICMP, ICMP_ROUTER_ADVERT, 0, 2,
                 ENTRY_SIZE_WORDS, 16'($urandom), 2, 10);
    send_frame();
    wait_drained();
  endtask

  task automatic test_extreme_frames();
    // largest address count, far more than the list carries
    build_advert(ETHERTYPE_IPV4, 15, 0, PROTO_ICMP, ICMP_ROUTER_ADVERT, 0, 8'd255,
                 ENTRY_SIZE_WORDS, 16'($urandom), MAX_ENTRIES + 1, 0);
    send_frame();
    build_advert(ETHERTYPE_IPV4, 15, 0, PROTO_ICMP, ICMP_ROUTER_ADVERT, 0, 3,
                 ENTRY_SIZE_WORDS, 16'($urandom), 3, 0);
    send_frame();
    wait_drained();
  endtask

  task automatic test_random_frames(input int min_bytes, input int min_records);
    int          byte_base;
    int          rec_base;
    int          pick;
    int          ihl;
    int          count;
    logic [15:0] etype;
    int          tot_adj;
    logic [7:0]  proto;
    logic [7:0]  icmp_type;
    logic [7:0]  code;
    logic [7:0]  size;
    int          n_list;
    byte_base = bytes_sent;
    rec_base = records_checked;
    while (bytes_sent - byte_base < min_bytes || records_checked - rec_base < min_records) begin
      pick = $urandom_range(99);
      if (pick >= 85) begin
        build_raw($urandom_range(1, 70));
      end else begin
        etype = ETHERTYPE_IPV4;
        ihl = ($urandom_range(3) == 0) ? $urandom_range(6, 15) : 5;
        count = ($urandom_range(4) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
        n_list = count;
        tot_adj = 0;
        proto = PROTO_ICMP;
        icmp_type = ICMP_ROUTER_ADVERT;
        code = 8'd0;
        size = ENTRY_SIZE_WORDS;
        if (pick >= 65) begin
          case ($urandom_range(8))
            0: etype = 16'($urandom);
            1: ihl = $urandom_range(0, 4);
            2: tot_adj = -$urandom_range(1, 8 * n_list + 8);
            3: tot_adj = $urandom_range(1, 16);
            4: proto = 8'($urandom);
            5: icmp_type = 8'($urandom);
            6: code = 8'($urandom);
            7: size = 8'($urandom);
            default: n_list = (count == 0) ? 0 : $urandom_range(0, count - 1);
          endcase
          if (count == 0 && n_list == 0 && pick >= 80) count = $urandom_range(1, 255);
        end
        build_advert(etype, 4'(ihl), tot_adj, proto, icmp_type, code, 8'(count), size,
                     16'($urandom), n_list, ($urandom_range(3) == 0) ? $urandom_range(1, 12) : 0);
      end
      send_frame();
      if ($urandom_range(7) == 0) wait_drained();
    end
    wait_drained();
  endtask

  always @(negedge clk) begin
    rec_stall <= !rst && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin : check_records
    record_beat_t got;
    record_beat_t want;
    if (!rst && rec_valid && !rec_stall) begin
      got = rec_data;
      if (pending_records.size() == 0) begin
        report_mismatch("record with nothing pending, kind", got.record_kind, 0);
      end else begin
        want = pending_records.pop_front();
        if (got.record_kind !== want.record_kind)
          report_mismatch("record_kind", got.record_kind, want.record_kind);
        if (got.verdict !== want.verdict)
          report_mismatch("verdict", got.verdict, want.verdict);
        if (got.source_address !== want.source_address)
          report_mismatch("source_address", got.source_address, want.source_address);
        if (got.dest_address !== want.dest_address)
          report_mismatch("dest_address", got.dest_address, want.dest_address);
        if (got.advert_lifetime !== want.advert_lifetime)
          report_mismatch("advert_lifetime", got.advert_lifetime, want.advert_lifetime);
        if (got.address_count !== want.address_count)
          report_mismatch("address_count", got.address_count, want.address_count);
        if (got.entries_truncated !== want.entries_truncated)
          report_mismatch("entries_truncated", got.entries_truncated, want.entries_truncated);
        if (got.router_address !== want.router_address)
          report_mismatch("router_address", got.router_address, want.router_address);
        if (got.preference_level !== want.preference_level)
          report_mismatch("preference_level", got.preference_level, want.preference_level);
        if (got.entry_number !== want.entry_number)
          report_mismatch("entry_number", got.entry_number, want.entry_number);
        if (got.last_record !== want.last_record)
          report_mismatch("last_record", got.last_record, want.last_record);
      end
      records_checked++;
    end
  end

  initial begin
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_data = '0;
    rec_stall = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 33;
    recv_idle_pct = 86;
    test_short_frames();
    test_rejected_frames();
    test_random_frames(100, 25);

    send_idle_pct = 86;
    recv_idle_pct = 33;
    test_accepted_frames();
    test_random_frames(100, 25);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_extreme_frames();
    test_random_frames(100, 25);

    wait_drained();
    repeat (40) @(posedge clk);
    if (pending_records.size() != 0)
      report_mismatch("records never produced, count", pending_records.size(), 0);
    $display("Ran %0d frames (%0d accepted, %0d bytes), %0d records checked",
             frames_sent, frames_accepted, bytes_sent, records_checked);
    $display("Verdict codes reached: %b", verdicts_seen);
    if (errors == 0) begin
      $display("router_advert_frame_checker_core test passed");
    end else begin
      $display("router_advert_frame_checker_core test failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("router_advert_frame_checker_core test failed");
    $finish;
  end

endmodule
